>>> rtl/lkv_pkg.sv
// ----------------------------------------------------------------------------
// lkv_pkg
// Shared types and constants for the lru key/value cache core.
// ----------------------------------------------------------------------------
package lkv_pkg;

	// field widths fixed by the interface
	localparam int KEY_W = 32;
	localparam int VAL_W = 32;
	localparam int CAP_W = 5;

	// operation codes carried on func
	localparam logic FUNC_GET = 1'b0;
	localparam logic FUNC_PUT = 1'b1;

	// capacity register reset value
	localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

	// value returned by a get that misses
	localparam logic [VAL_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;    // capture a new transaction and its lookup result
		logic commit;  // update the table and load the result register
		logic cfg_we;  // write the capacity register
	} dp_cmd_t;

endpackage

>>> rtl/lkv_ctrl.sv
// ----------------------------------------------------------------------------
// lkv_ctrl
// Controller: two-state sequencer (lookup capture, table update) plus the
// output valid register and the handshakes of all three channels.
// ----------------------------------------------------------------------------
module lkv_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	output lkv_pkg::dp_cmd_t cmd
);

	localparam logic S_IDLE   = 1'b0;
	localparam logic S_UPDATE = 1'b1;

	logic state_q;
	logic out_valid_q;
	logic out_free;

	// handshakes
	assign in_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || !out_stall;

	// commands
	always_comb begin
		cmd.load   = in_valid && (state_q == S_IDLE);
		cmd.commit = (state_q == S_UPDATE) && out_free;
		cmd.cfg_we = cfg_valid && (state_q == S_IDLE);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.load) state_q <= S_UPDATE;
				end
				S_UPDATE: begin
					if (cmd.commit) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.commit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/lkv_datapath.sv
// ----------------------------------------------------------------------------
// lkv_datapath
// Datapath: register table of keys, values and recency ranks, parallel key
// compare, capture stage, recency update and the result register.
// ----------------------------------------------------------------------------
module lkv_datapath #(
	parameter int ENTRIES = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lkv_pkg::dp_cmd_t              cmd,
	input  logic                          func,
	input  logic [lkv_pkg::KEY_W-1:0]     key,
	input  logic [lkv_pkg::VAL_W-1:0]     value,
	input  logic [lkv_pkg::CAP_W-1:0]     cfg_data,
	output logic                          hit,
	output logic [lkv_pkg::VAL_W-1:0]     read_value
);

	localparam int CW = $clog2(ENTRIES + 1);
	localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	// table
	logic [ENTRIES-1:0]          valid_q;
	logic [lkv_pkg::KEY_W-1:0]   ent_key_q   [ENTRIES];
	logic [lkv_pkg::VAL_W-1:0]   ent_value_q [ENTRIES];
	logic [RW-1:0]               ent_rank_q  [ENTRIES];
	logic [CW-1:0]               fill_q;
	logic [lkv_pkg::CAP_W-1:0]   cap_q;

	// capture stage
	logic                        func_s1;
	logic [lkv_pkg::KEY_W-1:0]   key_s1;
	logic [lkv_pkg::VAL_W-1:0]   value_s1;
	logic [ENTRIES-1:0]          match_s1;
	logic                        hit_s1;

	// result register
	logic                        hit_q;
	logic [lkv_pkg::VAL_W-1:0]   read_value_q;

	logic [ENTRIES-1:0]          match;
	logic [ENTRIES-1:0]          match_first;
	logic [ENTRIES-1:0]          free_vec;
	logic [ENTRIES-1:0]          free_first;
	logic [ENTRIES-1:0]          victim;
	logic [ENTRIES-1:0]          target;
	logic [RW-1:0]               hit_rank;
	logic [lkv_pkg::VAL_W-1:0]   hit_val;
	logic [CW-1:0]               eff_cap;
	logic [CW-1:0]               fill_m1;
	logic [CW-1:0]               limit;
	logic                        full;
	logic                        is_put;
	logic                        insert;
	logic                        do_write;
	logic [lkv_pkg::VAL_W-1:0]   result_val;

	// parallel key compare against the table
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			match[i] = valid_q[i] && (ent_key_q[i] == key);
		end
	end
	assign match_first = match & (~match + ENTRIES'(1));

	// capture stage
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_s1  <= func;
			key_s1   <= key;
			value_s1 <= value;
			match_s1 <= match_first;
			hit_s1   <= |match;
		end
	end

	// rank and value of the matching entry
	always_comb begin
		hit_rank = '0;
		hit_val  = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			if (match_s1[i]) begin
				hit_rank = hit_rank | ent_rank_q[i];
				hit_val  = hit_val | ent_value_q[i];
			end
		end
	end

	// effective capacity, clamped to one through ENTRIES
	always_comb begin
		priority if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > ENTRIES) begin
			eff_cap = CW'(ENTRIES);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	assign full    = (fill_q >= eff_cap);
	assign fill_m1 = fill_q - CW'(1);

	// least recent entry holds the largest rank, fill minus one
	always_comb begin
		for (int i = 0; i < ENTRIES; i++) begin
			victim[i] = valid_q[i] && (CW'(ent_rank_q[i]) == fill_m1);
		end
	end

	// first free slot
	assign free_vec   = ~valid_q;
	assign free_first = free_vec & (~free_vec + ENTRIES'(1));

	// slot to promote and the rank bound below which entries age
	assign is_put   = (func_s1 == lkv_pkg::FUNC_PUT);
	assign insert   = is_put && !hit_s1;
	assign do_write = cmd.commit && (is_put || hit_s1);

	always_comb begin
		priority if (hit_s1) begin
			target = match_s1;
			limit  = CW'(hit_rank);
		end else if (full) begin
			target = victim;
			limit  = fill_m1;
		end else begin
			target = free_first;
			limit  = fill_q;
		end
	end

	// table payload update
	always_ff @(posedge clk) begin
		if (do_write) begin
			for (int i = 0; i < ENTRIES; i++) begin
				if (target[i]) begin
					ent_rank_q[i] <= '0;
					if (is_put) ent_value_q[i] <= value_s1;
					if (insert) ent_key_q[i] <= key_s1;
				end else if (valid_q[i] && (CW'(ent_rank_q[i]) < limit)) begin
					ent_rank_q[i] <= ent_rank_q[i] + RW'(1);
				end
			end
		end
	end

	// valid bits and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			fill_q  <= '0;
		end else if (do_write && insert && !full) begin
			valid_q <= valid_q | target;
			fill_q  <= fill_q + CW'(1);
		end
	end

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= lkv_pkg::CAP_RESET;
		end else if (cmd.cfg_we) begin
			cap_q <= cfg_data;
		end
	end

	// result selection
	always_comb begin
		priority if (is_put) begin
			result_val = '0;
		end else if (hit_s1) begin
			result_val = hit_val;
		end else begin
			result_val = lkv_pkg::MISS_VALUE;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit_q        <= hit_s1;
			read_value_q <= result_val;
		end
	end

	assign hit        = hit_q;
	assign read_value = read_value_q;

endmodule

>>> rtl/lru_key_value_cache_core.sv
// ----------------------------------------------------------------------------
// lru_key_value_cache_core
// Fully associative key/value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Each transaction is a get (func 0) or a put (func 1). The key is compared
// against all ENTRIES table entries in the cycle the transaction is accepted;
// the capture stage registers it, then the update step updates recency ranks,
// the value and key and loads the result register, waiting while an earlier
// result is still stalled. in_stall stays high until the update step is done,
// so no new transaction is accepted before then. out_valid rises as the update
// step loads the result. A result waiting on out_stall does not block the next
// acceptance, only its update step. hit reports a key present before the
// operation; read_value is the stored value on a get hit, all ones on a get
// miss and zero on a put. capacity (cfg_data) is clamped to 1..ENTRIES and is
// written only while no transaction is in flight; lowering it below the
// current fill keeps existing entries and evicts one per later put miss.
// ----------------------------------------------------------------------------
module lru_key_value_cache_core #(
	parameter int ENTRIES = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic                      func,
	input  logic [lkv_pkg::KEY_W-1:0] key,
	input  logic [lkv_pkg::VAL_W-1:0] value,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic                      hit,
	output logic [lkv_pkg::VAL_W-1:0] read_value,
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [lkv_pkg::CAP_W-1:0] cfg_data
);

	lkv_pkg::dp_cmd_t cmd;

	// controller
	lkv_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cmd       (cmd)
	);

	// datapath
	lkv_datapath #(
		.ENTRIES (ENTRIES)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.func       (func),
		.key        (key),
		.value      (value),
		.cfg_data   (cfg_data),
		.hit        (hit),
		.read_value (read_value)
	);

endmodule

>>> rtl/lkv_checker.sv
// ----------------------------------------------------------------------------
// lkv_checker
// Port-level checks for the lru key/value cache core, bound to the top level.
// ----------------------------------------------------------------------------
module lkv_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_stall,
	input logic                      out_valid,
	input logic                      out_stall,
	input logic                      hit,
	input logic [lkv_pkg::VAL_W-1:0] read_value
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(hit) && $stable(read_value))
		else $error("stalled result changed");

	// an accepted transaction keeps the block busy for its update cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input not stalled during update");

	// a miss reports all ones (get) or zero (put)
	a_miss_value: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> (read_value == '0) || (read_value == lkv_pkg::MISS_VALUE))
		else $error("miss with unexpected read value");

	// a new result comes only from the update cycle
	a_result_from_update: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_stall))
		else $error("result without a transaction in flight");

endmodule

bind lru_key_value_cache_core lkv_checker u_lkv_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.hit        (hit),
	.read_value (read_value)
);
